FILE: rtl/core/sfa_pkg.sv
// Shared types, constants and fixed-point helpers for the series function approximator.
// Used by sfa_mul, sfa_div and series_function_approximator. No dependencies.
`default_nettype none

package sfa_pkg;

  localparam int MAX_TERMS_DEF      = 50;
  localparam int MAX_TRIG_TERMS_DEF = 10;

  localparam logic [3:0] OP_EXP  = 4'd0;
  localparam logic [3:0] OP_GEO1 = 4'd1;
  localparam logic [3:0] OP_GEO2 = 4'd2;
  localparam logic [3:0] OP_GEO3 = 4'd3;
  localparam logic [3:0] OP_LN1P = 4'd4;
  localparam logic [3:0] OP_LN1M = 4'd5;
  localparam logic [3:0] OP_PI   = 4'd6;
  localparam logic [3:0] OP_COS  = 4'd7;
  localparam logic [3:0] OP_SIN  = 4'd8;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_ERR = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  // Argument limits in Q16.16.
  localparam logic signed [31:0] X_ONE     = 32'sd65536;
  localparam logic signed [31:0] X_DEG_LIM = 32'sd23592960;

  // Q31.32 constants.
  localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  // Degrees to radians as 314/18000.
  localparam logic [63:0] RAD_MUL = 64'd314;
  localparam logic [14:0] RAD_DIV = 15'd18000;

  localparam int DIV_STEPS = 65;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG_MUL,
    ST_TRIG_DIV,
    ST_SQ,
    ST_CHECK,
    ST_POW,
    ST_TERM,
    ST_NEG,
    ST_ACC,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [3:0]         operation;
    logic [5:0]         term_count;
    logic signed [31:0] x_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
  } out_beat_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [64:0] dividend;
    logic [14:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [64:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic signed [63:0] v;
    logic               sat;
  } fix_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

  // Signed value from sign and magnitude, clamped to the Q31.32 range.
  function automatic fix_t from_mag(input logic neg, input logic [64:0] m);
    fix_t f;
    f.sat = 1'b0;
    if (neg) begin
      if (m > 65'h0_8000_0000_0000_0000) begin
        f.sat = 1'b1;
        f.v   = Q_MIN;
      end else begin
        f.v = 64'd0 - m[63:0];
      end
    end else begin
      if (m > 65'h0_7FFF_FFFF_FFFF_FFFF) begin
        f.sat = 1'b1;
        f.v   = Q_MAX;
      end else begin
        f.v = m[63:0];
      end
    end
    return f;
  endfunction

  // Fixed-point product: round the 128-bit magnitude product to nearest at bit 32.
  function automatic fix_t mulq_fix(input logic [127:0] prod, input logic neg);
    logic [127:0] rnd;
    logic [64:0]  m;
    rnd = prod + 128'h8000_0000;
    m   = (rnd[127:96] != 32'd0) ? {1'b0, 64'hFFFF_FFFF_FFFF_FFFF} : {1'b0, rnd[95:32]};
    return from_mag(neg, m);
  endfunction

  // Product with an integer factor.
  function automatic fix_t muli_fix(input logic [127:0] prod, input logic neg);
    logic [64:0] m;
    m = (prod[127:64] != 64'd0) ? {1'b0, 64'hFFFF_FFFF_FFFF_FFFF} : {1'b0, prod[63:0]};
    return from_mag(neg, m);
  endfunction

  function automatic fix_t add_q(input logic signed [63:0] a, input logic signed [63:0] b);
    fix_t              f;
    logic signed [64:0] s;
    s     = {a[63], a} + {b[63], b};
    f.sat = 1'b0;
    if (s[64] != s[63]) begin
      f.sat = 1'b1;
      f.v   = s[64] ? Q_MIN : Q_MAX;
    end else begin
      f.v = s[63:0];
    end
    return f;
  endfunction

  function automatic fix_t neg_q(input logic signed [63:0] a);
    fix_t f;
    f.sat = (a == Q_MIN);
    f.v   = (a == Q_MIN) ? Q_MAX : (64'sd0 - a);
    return f;
  endfunction

  // Rounded division dividend: magnitude plus half the divisor.
  function automatic logic [64:0] div_dvd(input logic signed [63:0] src,
                                          input logic [14:0] k);
    return {1'b0, mag64(src)} + 65'(k >> 1);
  endfunction

  // First series index of each function.
  function automatic logic [5:0] start_index(input logic [3:0] op);
    logic [5:0] s;
    case (op)
      OP_GEO2, OP_LN1P, OP_LN1M: s = 6'd1;
      OP_GEO3:                   s = 6'd2;
      default:                   s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sfa_mul.sv
// Shared multiplier: 64 by 64 bit unsigned product built from one 32 by 32 multiplier.
// Four passes, one partial product each. Depends on sfa_pkg.
`default_nettype none

module sfa_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sfa_pkg::mul_req_t req,
  output sfa_pkg::mul_rsp_t      rsp
);
  import sfa_pkg::*;

  logic         busy_r;
  logic         done_r;
  logic [1:0]   step_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [127:0] acc_r;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    a_half = step_r[0] ? a_r[63:32] : a_r[31:0];
    b_half = step_r[1] ? b_r[63:32] : b_r[31:0];
    pp     = 64'(a_half) * 64'(b_half);
    case (step_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

`default_nettype wire

FILE: rtl/core/sfa_div.sv
// Shared divider: restoring division of a 65-bit dividend by a 15-bit divisor.
// One quotient bit per cycle. Depends on sfa_pkg.
`default_nettype none

module sfa_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sfa_pkg::div_req_t req,
  output sfa_pkg::div_rsp_t      rsp
);
  import sfa_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [64:0] sh_r;
  logic [14:0] rem_r;
  logic [14:0] dvs_r;
  logic [15:0] trial;
  logic [15:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem_r, sh_r[64]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (req.start) begin
      sh_r  <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[63:0], ge};
      rem_r <= ge ? diff[14:0] : trial[14:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = sh_r;

endmodule

`default_nettype wire

FILE: rtl/core/series_function_approximator.sv
// Series function approximator top level: request checking, term sequencer and accumulator.
// Instantiates sfa_mul and sfa_div; depends on sfa_pkg.
//
// Each input beat selects a function (exp, 1/(1-x) and its square and cube, ln(1+x),
// ln(1-x), the Leibniz series for pi, cos or sin of an angle in degrees), a term count N
// and a Q16.16 argument, and produces one output beat holding the truncated series sum in
// signed Q31.32 plus a status code. A request with an invalid select, too many terms or an
// argument outside the function's domain returns zero with the error status. Any product,
// term, partial sum or negation that leaves the Q31.32 range clamps, work goes on with the
// clamped value, and the status reports saturation. The block handles one request at a
// time and holds in_stall high while it works. Every 64-bit product and every quotient runs
// through one shared 32x32 multiplier, used in four passes per 64-bit product, and one
// shared restoring divider that retires one quotient bit per cycle. A term needs at most
// two products, or one product and one quotient, plus sequencing states; cos and sin
// first add the degree conversion (a product and a quotient) and the squared argument,
// and a rejected request skips the series and goes straight to the output state. The
// output beat sits in a register, so a new request is taken while the previous result
// waits for the sink.
`default_nettype none

module series_function_approximator #(
  parameter int MAX_TERMS      = sfa_pkg::MAX_TERMS_DEF,
  parameter int MAX_TRIG_TERMS = sfa_pkg::MAX_TRIG_TERMS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sfa_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sfa_pkg::out_beat_t     out_data
);
  import sfa_pkg::*;

  state_t             state_r, state_nxt;
  logic [3:0]         op_r, op_nxt;
  logic [5:0]         n_r, n_nxt;
  logic [5:0]         b_r, b_nxt;
  logic signed [63:0] x_r, x_nxt;      // argument, later the squared angle for cos and sin
  logic signed [63:0] w_r, w_nxt;      // running power or running term
  logic signed [63:0] tm_r, tm_nxt;    // term to be added
  logic signed [63:0] acc_r, acc_nxt;
  logic               sat_r, sat_nxt;
  logic               err_r, err_nxt;
  logic               launched_r, launched_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r, out_data_nxt;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        bad;
  logic        is_trig;
  logic [11:0] tri_prod;
  logic [11:0] int_k;
  logic [13:0] two_b;
  logic [13:0] d_lo;
  logic [13:0] d_hi;
  logic [13:0] trig_d;
  fix_t        fx;

  sfa_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  sfa_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Request checking against each function's domain.
  always_comb begin
    bad = 1'b0;
    if (in_data.operation > OP_SIN) begin
      bad = 1'b1;
    end else if (in_data.operation >= OP_COS) begin
      bad = (in_data.term_count > 6'(MAX_TRIG_TERMS)) ||
            (in_data.x_value < -X_DEG_LIM) || (in_data.x_value > X_DEG_LIM);
    end else begin
      if (in_data.term_count > 6'(MAX_TERMS)) bad = 1'b1;
      if ((in_data.operation == OP_GEO1 || in_data.operation == OP_GEO2 ||
           in_data.operation == OP_GEO3) &&
          (in_data.x_value <= -X_ONE || in_data.x_value >= X_ONE)) bad = 1'b1;
      if (in_data.operation == OP_LN1P &&
          (in_data.x_value <= -X_ONE || in_data.x_value > X_ONE)) bad = 1'b1;
      if (in_data.operation == OP_LN1M && in_data.x_value > X_ONE) bad = 1'b1;
    end
  end

  // Integer factors: b for the squared series, (b-1)b/2 for the cubed one, and the two new
  // factorial factors for cos and sin.
  always_comb begin
    is_trig  = (op_r == OP_COS) || (op_r == OP_SIN);
    tri_prod = (12'(b_r) - 12'd1) * 12'(b_r);
    int_k    = (op_r == OP_GEO2) ? 12'(b_r) : (tri_prod >> 1);
    two_b    = {7'd0, b_r, 1'b0};
    d_lo     = (op_r == OP_COS) ? (two_b - 14'd1) : two_b;
    d_hi     = (op_r == OP_COS) ? two_b : (two_b + 14'd1);
    trig_d   = d_lo * d_hi;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    n_nxt         = n_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    w_nxt         = w_r;
    tm_nxt        = tm_r;
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    err_nxt       = err_r;
    launched_nxt  = launched_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mul_req       = '0;
    div_req       = '0;
    fx            = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_data.operation;
          n_nxt        = in_data.term_count;
          b_nxt        = start_index(in_data.operation);
          x_nxt        = {{16{in_data.x_value[31]}}, in_data.x_value, 16'h0000};
          w_nxt        = (in_data.operation == OP_LN1P || in_data.operation == OP_LN1M) ?
                         {{16{in_data.x_value[31]}}, in_data.x_value, 16'h0000} : Q_ONE;
          acc_nxt      = '0;
          sat_nxt      = 1'b0;
          err_nxt      = bad;
          launched_nxt = 1'b0;
          if (bad) begin
            state_nxt = ST_OUT;
          end else if (in_data.operation == OP_COS || in_data.operation == OP_SIN) begin
            state_nxt = ST_TRIG_MUL;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end

      // Degrees times 314, exact.
      ST_TRIG_MUL: begin
        if (!launched_r) begin
          mul_req.start = 1'b1;
          mul_req.a     = mag64(x_r);
          mul_req.b     = RAD_MUL;
          launched_nxt  = 1'b1;
        end else if (mul_rsp.done) begin
          fx           = muli_fix(mul_rsp.prod, x_r[63]);
          w_nxt        = fx.v;
          launched_nxt = 1'b0;
          state_nxt    = ST_TRIG_DIV;
        end
      end

      // Divide by 18000 to get the angle in radians.
      ST_TRIG_DIV: begin
        if (!launched_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_dvd(w_r, RAD_DIV);
          div_req.divisor  = RAD_DIV;
          launched_nxt     = 1'b1;
        end else if (div_rsp.done) begin
          fx           = from_mag(w_r[63], div_rsp.quotient);
          tm_nxt       = fx.v;
          sat_nxt      = sat_r | fx.sat;
          launched_nxt = 1'b0;
          state_nxt    = ST_SQ;
        end
      end

      // Square of the angle; it replaces the argument as the per-term multiplier.
      ST_SQ: begin
        if (!launched_r) begin
          mul_req.start = 1'b1;
          mul_req.a     = mag64(tm_r);
          mul_req.b     = mag64(tm_r);
          launched_nxt  = 1'b1;
        end else if (mul_rsp.done) begin
          fx           = mulq_fix(mul_rsp.prod, 1'b0);
          x_nxt        = fx.v;
          sat_nxt      = sat_r | fx.sat;
          w_nxt        = (op_r == OP_COS) ? Q_ONE : tm_r;
          launched_nxt = 1'b0;
          state_nxt    = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (b_r < n_r) begin
          if (op_r != OP_PI && b_r > start_index(op_r)) begin
            state_nxt = ST_POW;
          end else begin
            state_nxt = ST_TERM;
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end

      // Advance the running power or term by one factor of the multiplier.
      ST_POW: begin
        if (!launched_r) begin
          mul_req.start = 1'b1;
          mul_req.a     = mag64(w_r);
          mul_req.b     = mag64(x_r);
          launched_nxt  = 1'b1;
        end else if (mul_rsp.done) begin
          fx           = mulq_fix(mul_rsp.prod, w_r[63] ^ x_r[63]);
          w_nxt        = fx.v;
          sat_nxt      = sat_r | fx.sat;
          launched_nxt = 1'b0;
          state_nxt    = ST_TERM;
        end
      end

      ST_TERM: begin
        case (op_r)
          OP_GEO1: begin
            tm_nxt    = w_r;
            state_nxt = ST_ACC;
          end
          OP_GEO2, OP_GEO3: begin
            if (!launched_r) begin
              mul_req.start = 1'b1;
              mul_req.a     = mag64(w_r);
              mul_req.b     = 64'(int_k);
              launched_nxt  = 1'b1;
            end else if (mul_rsp.done) begin
              fx           = muli_fix(mul_rsp.prod, w_r[63]);
              tm_nxt       = fx.v;
              sat_nxt      = sat_r | fx.sat;
              launched_nxt = 1'b0;
              state_nxt    = ST_ACC;
            end
          end
          OP_EXP, OP_COS, OP_SIN: begin
            if (b_r == 6'd0) begin
              tm_nxt    = w_r;
              state_nxt = ST_ACC;
            end else if (!launched_r) begin
              div_req.start    = 1'b1;
              div_req.divisor  = (op_r == OP_EXP) ? 15'(b_r) : 15'(trig_d);
              div_req.dividend = div_dvd(w_r, div_req.divisor);
              launched_nxt     = 1'b1;
            end else if (div_rsp.done) begin
              fx           = from_mag(w_r[63], div_rsp.quotient);
              tm_nxt       = fx.v;
              sat_nxt      = sat_r | fx.sat;
              launched_nxt = 1'b0;
              if (op_r == OP_EXP) begin
                w_nxt     = fx.v;
                state_nxt = ST_ACC;
              end else begin
                state_nxt = ST_NEG;
              end
            end
          end
          OP_LN1P, OP_LN1M: begin
            if (!launched_r) begin
              div_req.start    = 1'b1;
              div_req.divisor  = 15'(b_r);
              div_req.dividend = div_dvd(w_r, 15'(b_r));
              launched_nxt     = 1'b1;
            end else if (div_rsp.done) begin
              fx           = from_mag(w_r[63], div_rsp.quotient);
              tm_nxt       = fx.v;
              sat_nxt      = sat_r | fx.sat;
              launched_nxt = 1'b0;
              state_nxt    = (op_r == OP_LN1P && !b_r[0]) ? ST_NEG : ST_ACC;
            end
          end
          OP_PI: begin
            if (!launched_r) begin
              div_req.start    = 1'b1;
              div_req.divisor  = 15'({b_r, 1'b1});
              div_req.dividend = div_dvd(Q_ONE, 15'({b_r, 1'b1}));
              launched_nxt     = 1'b1;
            end else if (div_rsp.done) begin
              fx           = from_mag(1'b0, div_rsp.quotient);
              tm_nxt       = fx.v;
              sat_nxt      = sat_r | fx.sat;
              launched_nxt = 1'b0;
              state_nxt    = b_r[0] ? ST_NEG : ST_ACC;
            end
          end
          default: begin
            state_nxt = ST_OUT;
          end
        endcase
      end

      // Alternating sign; for cos and sin the negated term is also the next running term.
      ST_NEG: begin
        fx      = neg_q(tm_r);
        tm_nxt  = fx.v;
        sat_nxt = sat_r | fx.sat;
        if (is_trig) w_nxt = fx.v;
        state_nxt = ST_ACC;
      end

      ST_ACC: begin
        fx        = add_q(acc_r, tm_r);
        acc_nxt   = fx.v;
        sat_nxt   = sat_r | fx.sat;
        b_nxt     = b_r + 6'd1;
        state_nxt = ST_CHECK;
      end

      ST_FIN: begin
        if (op_r == OP_LN1M) begin
          fx        = neg_q(acc_r);
          acc_nxt   = fx.v;
          sat_nxt   = sat_r | fx.sat;
          state_nxt = ST_OUT;
        end else if (op_r == OP_PI) begin
          if (!launched_r) begin
            mul_req.start = 1'b1;
            mul_req.a     = mag64(acc_r);
            mul_req.b     = 64'd4;
            launched_nxt  = 1'b1;
          end else if (mul_rsp.done) begin
            fx           = muli_fix(mul_rsp.prod, acc_r[63]);
            acc_nxt      = fx.v;
            sat_nxt      = sat_r | fx.sat;
            launched_nxt = 1'b0;
            state_nxt    = ST_OUT;
          end
        end else begin
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_value = err_r ? 64'sd0 : acc_r;
          out_data_nxt.status       = err_r ? STATUS_ERR : (sat_r ? STATUS_SAT : STATUS_OK);
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    n_r        <= n_nxt;
    b_r        <= b_nxt;
    x_r        <= x_nxt;
    w_r        <= w_nxt;
    tm_r       <= tm_nxt;
    acc_r      <= acc_nxt;
    sat_r      <= sat_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
